// File: src/pcm_pkg.sv
// ----------------------------------------------------------------------------
// pcm_pkg
// shared types, sizes, codes and the crc byte update for the chunk minifier
// ----------------------------------------------------------------------------
package pcm_pkg;

   localparam int MAX_BYTES = 1048576;
   localparam int ADDR_W    = $clog2(MAX_BYTES);
   localparam int CNT_W     = $clog2(MAX_BYTES + 1);
   localparam int OUT_DEPTH = MAX_BYTES + 16;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);
   localparam int LEN_W     = 21;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_FINISH = 2'd1;
   localparam logic [1:0] OP_FETCH  = 2'd2;

   localparam logic KIND_REPORT = 1'b0;
   localparam logic KIND_BYTE   = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_SIG = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_TOO_BIG = 2'd3;

   localparam logic [63:0] PNG_SIG  = 64'h89504E470D0A1A0A;
   localparam logic [31:0] TY_IHDR  = 32'h49484452;
   localparam logic [31:0] TY_PLTE  = 32'h504C5445;
   localparam logic [31:0] TY_TRNS  = 32'h74524E53;
   localparam logic [31:0] TY_IDAT  = 32'h49444154;
   localparam logic [31:0] TY_IEND  = 32'h49454E44;
   localparam logic [31:0] CRC_POLY = 32'hEDB88320;
   localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

   typedef struct packed {
      logic             done;
      logic [1:0]       status;
      logic [LEN_W-1:0] total;
   } pcm_fin_type;

   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: src/pcm_if.sv
// ----------------------------------------------------------------------------
// pcm channel interfaces
// request and response channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface pcm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] data_byte;
   modport source (output valid, output opcode, output data_byte, input ready);
   modport sink (input valid, input opcode, input data_byte, output ready);
endinterface

interface pcm_rsp_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [1:0]                status;
   logic [pcm_pkg::LEN_W-1:0] out_length;
   logic [7:0]                out_byte;
   logic                      last_byte;
   logic                      past_end;
   modport source (output valid, output kind, output status, output out_length,
                   output out_byte, output last_byte, output past_end, input ready);
   modport sink (input valid, input kind, input status, input out_length,
                 input out_byte, input last_byte, input past_end, output ready);
endinterface

// File: src/pcm_byte_ram.sv
// ----------------------------------------------------------------------------
// pcm_byte_ram
// byte wide memory, one write port and one read port, registered read data
// ----------------------------------------------------------------------------
module pcm_byte_ram #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [7:0]    wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [7:0]    rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/pcm_walker.sv
// ----------------------------------------------------------------------------
// pcm_walker
// finish sequencer: checks the signature, walks the chunks in the file memory
// and writes the minified file with fresh crcs into the output memory
// ----------------------------------------------------------------------------
module pcm_walker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      overflow,
   input  logic [pcm_pkg::CNT_W-1:0] byte_count,
   output logic [pcm_pkg::ADDR_W-1:0] file_rd_addr,
   input  logic [7:0]                file_rd_data,
   output logic                      out_wr_en,
   output logic [pcm_pkg::OUT_AW-1:0] out_wr_addr,
   output logic [7:0]                out_wr_data,
   output pcm_pkg::pcm_fin_type      fin
);

   typedef enum logic [4:0] {
      S_IDLE, S_HDR, S_SIG_CHK, S_SIG2, S_START_WALK, S_WALK, S_CHECK, S_EMIT,
      S_COPY_RD, S_COPY_WR, S_END0, S_M_IDAT, S_END1_A, S_END1_B, S_END1_C,
      S_END1_D, S_FIN_OK, S_REPORT
   } state_type;

   state_type                   state_ff, ret_ff;
   logic [pcm_pkg::CNT_W-1:0]   i_ff, src_ff, cnt_ff, merged_ff;
   logic [63:0]                 hdr_ff;
   logic [3:0]                  hcnt_ff;
   logic [31:0]                 word_ff, crc_ff;
   logic [1:0]                  wcnt_ff;
   logic                        wcrc_ff, seen_ff, pass_ff, sig_mode_ff;
   logic [1:0]                  status_ff;
   logic [pcm_pkg::LEN_W-1:0]   total_ff;

   logic [pcm_pkg::CNT_W-1:0]   hdr_addr;
   logic [31:0]                 len, typ;
   logic [33:0]                 end_sum;
   logic                        hdr_fits;

   assign hdr_addr = i_ff + pcm_pkg::CNT_W'(hcnt_ff[2:0]);
   assign len      = hdr_ff[63:32];
   assign typ      = hdr_ff[31:0];
   assign end_sum  = 34'(i_ff) + 34'(len) + 34'(12);
   assign hdr_fits = ({1'b0, i_ff} + (pcm_pkg::CNT_W + 1)'(8)) <= {1'b0, byte_count};

   assign file_rd_addr = (state_ff == S_HDR) ? hdr_addr[pcm_pkg::ADDR_W-1:0]
                                             : src_ff[pcm_pkg::ADDR_W-1:0];
   assign out_wr_en    = (state_ff == S_EMIT) || (state_ff == S_COPY_WR);
   assign out_wr_addr  = pcm_pkg::OUT_AW'(total_ff);
   assign out_wr_data  = (state_ff == S_EMIT) ? word_ff[31:24] : file_rd_data;

   assign fin.done   = (state_ff == S_REPORT);
   assign fin.status = status_ff;
   assign fin.total  = total_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         ret_ff      <= S_IDLE;
         status_ff   <= pcm_pkg::ST_OK;
         total_ff    <= '0;
         merged_ff   <= '0;
         seen_ff     <= 1'b0;
         pass_ff     <= 1'b0;
         sig_mode_ff <= 1'b0;
         hcnt_ff     <= '0;
         wcnt_ff     <= '0;
         wcrc_ff     <= 1'b0;
         crc_ff      <= pcm_pkg::CRC_INIT;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  total_ff  <= '0;
                  merged_ff <= '0;
                  seen_ff   <= 1'b0;
                  pass_ff   <= 1'b0;
                  if (overflow) begin
                     status_ff <= pcm_pkg::ST_TOO_BIG;
                     state_ff  <= S_REPORT;
                  end else if (byte_count < pcm_pkg::CNT_W'(8)) begin
                     status_ff <= pcm_pkg::ST_BAD_SIG;
                     state_ff  <= S_REPORT;
                  end else begin
                     i_ff        <= '0;
                     hcnt_ff     <= '0;
                     sig_mode_ff <= 1'b1;
                     state_ff    <= S_HDR;
                  end
               end
            end
            S_HDR: begin
               hcnt_ff <= hcnt_ff + 4'd1;
               if (hcnt_ff != 4'd0) begin
                  hdr_ff <= {hdr_ff[55:0], file_rd_data};
               end
               if (hcnt_ff == 4'd8) begin
                  state_ff <= sig_mode_ff ? S_SIG_CHK : S_CHECK;
               end
            end
            S_SIG_CHK: begin
               if (hdr_ff != pcm_pkg::PNG_SIG) begin
                  status_ff <= pcm_pkg::ST_BAD_SIG;
                  state_ff  <= S_REPORT;
               end else begin
                  word_ff  <= pcm_pkg::PNG_SIG[63:32];
                  wcrc_ff  <= 1'b0;
                  ret_ff   <= S_SIG2;
                  state_ff <= S_EMIT;
               end
            end
            S_SIG2: begin
               word_ff  <= pcm_pkg::PNG_SIG[31:0];
               wcrc_ff  <= 1'b0;
               ret_ff   <= S_START_WALK;
               state_ff <= S_EMIT;
            end
            S_START_WALK: begin
               i_ff        <= pcm_pkg::CNT_W'(8);
               sig_mode_ff <= 1'b0;
               state_ff    <= S_WALK;
            end
            S_WALK: begin
               hcnt_ff <= '0;
               if (hdr_fits) begin
                  state_ff <= S_HDR;
               end else begin
                  state_ff <= pass_ff ? S_END1_A : S_END0;
               end
            end
            S_CHECK: begin
               if ((end_sum > 34'(byte_count)) || (typ == pcm_pkg::TY_IEND)) begin
                  state_ff <= pass_ff ? S_END1_A : S_END0;
               end else begin
                  i_ff <= end_sum[pcm_pkg::CNT_W-1:0];
                  if (!pass_ff) begin
                     if ((typ == pcm_pkg::TY_IHDR) || (typ == pcm_pkg::TY_PLTE) ||
                         (typ == pcm_pkg::TY_TRNS)) begin
                        if (typ == pcm_pkg::TY_IHDR) begin
                           seen_ff <= 1'b1;
                        end
                        src_ff   <= i_ff + pcm_pkg::CNT_W'(4);
                        cnt_ff   <= len[pcm_pkg::CNT_W-1:0] + pcm_pkg::CNT_W'(4);
                        crc_ff   <= pcm_pkg::CRC_INIT;
                        word_ff  <= len;
                        wcrc_ff  <= 1'b0;
                        ret_ff   <= S_COPY_RD;
                        state_ff <= S_EMIT;
                     end else begin
                        if (typ == pcm_pkg::TY_IDAT) begin
                           merged_ff <= merged_ff + len[pcm_pkg::CNT_W-1:0];
                        end
                        state_ff <= S_WALK;
                     end
                  end else if (typ == pcm_pkg::TY_IDAT) begin
                     src_ff   <= i_ff + pcm_pkg::CNT_W'(8);
                     cnt_ff   <= len[pcm_pkg::CNT_W-1:0];
                     state_ff <= S_COPY_RD;
                  end else begin
                     state_ff <= S_WALK;
                  end
               end
            end
            S_EMIT: begin
               total_ff <= total_ff + pcm_pkg::LEN_W'(1);
               if (wcrc_ff) begin
                  crc_ff <= pcm_pkg::crc_byte(crc_ff, word_ff[31:24]);
               end
               word_ff <= {word_ff[23:0], 8'd0};
               wcnt_ff <= wcnt_ff + 2'd1;
               if (wcnt_ff == 2'd3) begin
                  state_ff <= ret_ff;
               end
            end
            S_COPY_RD: begin
               if (cnt_ff == '0) begin
                  if (!pass_ff) begin
                     word_ff  <= ~crc_ff;
                     wcrc_ff  <= 1'b0;
                     ret_ff   <= S_WALK;
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_WALK;
                  end
               end else begin
                  state_ff <= S_COPY_WR;
               end
            end
            S_COPY_WR: begin
               total_ff <= total_ff + pcm_pkg::LEN_W'(1);
               crc_ff   <= pcm_pkg::crc_byte(crc_ff, file_rd_data);
               src_ff   <= src_ff + pcm_pkg::CNT_W'(1);
               cnt_ff   <= cnt_ff - pcm_pkg::CNT_W'(1);
               state_ff <= S_COPY_RD;
            end
            S_END0: begin
               if (!seen_ff || (merged_ff == '0)) begin
                  status_ff <= pcm_pkg::ST_MISSING;
                  total_ff  <= '0;
                  state_ff  <= S_REPORT;
               end else begin
                  word_ff  <= 32'(merged_ff);
                  wcrc_ff  <= 1'b0;
                  ret_ff   <= S_M_IDAT;
                  state_ff <= S_EMIT;
               end
            end
            S_M_IDAT: begin
               crc_ff   <= pcm_pkg::CRC_INIT;
               pass_ff  <= 1'b1;
               word_ff  <= pcm_pkg::TY_IDAT;
               wcrc_ff  <= 1'b1;
               ret_ff   <= S_START_WALK;
               state_ff <= S_EMIT;
            end
            S_END1_A: begin
               word_ff  <= ~crc_ff;
               wcrc_ff  <= 1'b0;
               ret_ff   <= S_END1_B;
               state_ff <= S_EMIT;
            end
            S_END1_B: begin
               word_ff  <= '0;
               wcrc_ff  <= 1'b0;
               ret_ff   <= S_END1_C;
               state_ff <= S_EMIT;
            end
            S_END1_C: begin
               crc_ff   <= pcm_pkg::CRC_INIT;
               word_ff  <= pcm_pkg::TY_IEND;
               wcrc_ff  <= 1'b1;
               ret_ff   <= S_END1_D;
               state_ff <= S_EMIT;
            end
            S_END1_D: begin
               word_ff  <= ~crc_ff;
               wcrc_ff  <= 1'b0;
               ret_ff   <= S_FIN_OK;
               state_ff <= S_EMIT;
            end
            S_FIN_OK: begin
               status_ff <= pcm_pkg::ST_OK;
               state_ff  <= S_REPORT;
            end
            S_REPORT: begin
               state_ff <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// File: src/png_chunk_minifier_unit.sv
// fetch reads the output memory into the response register, past the end it fills
// that register directly; finish reads chunk headers on each of two passes, copies
// bytes in a read and a write state, writes length, type and crc words byte-wise,
// paced by the file memory read port. a load every cycle while idle and no response
// stalls; fetch and finish hold off requests until their byte or report word is out
// reset: synchronous, clears control state; memories keep their contents
// ----------------------------------------------------------------------------
// png_chunk_minifier_unit
// loads a png file, minifies it on finish and returns the result byte-wise
// ----------------------------------------------------------------------------
module png_chunk_minifier_unit (
   input  logic      clock,
   input  logic      reset,
   pcm_req_if.sink   req_bus,
   pcm_rsp_if.source rsp_bus
);

   typedef enum logic [1:0] {T_IDLE, T_FINISH, T_FETCH} state_type;

   state_type                   state_ff;
   logic [pcm_pkg::CNT_W-1:0]   count_ff, count_eff;
   logic                        overflow_ff, phase_done_ff, last_ff;
   logic [1:0]                  status_ff;
   logic [pcm_pkg::LEN_W-1:0]   pos_ff;

   logic                        rsp_valid_ff, rsp_kind_ff, rsp_last_ff, rsp_past_ff;
   logic [1:0]                  rsp_status_ff;
   logic [pcm_pkg::LEN_W-1:0]   rsp_len_ff;
   logic [7:0]                  rsp_byte_ff;

   logic                        accept, start, file_wr_en, fetch_ok, rsp_set;
   logic [pcm_pkg::ADDR_W-1:0]  file_rd_addr;
   logic [7:0]                  file_rd_data, out_rd_data, out_wr_data;
   logic                        out_wr_en;
   logic [pcm_pkg::OUT_AW-1:0]  out_wr_addr;
   pcm_pkg::pcm_fin_type        fin;

   assign req_bus.ready = (state_ff == T_IDLE) && (!rsp_valid_ff || rsp_bus.ready);
   assign accept        = req_bus.valid && req_bus.ready;
   assign start         = accept && (req_bus.opcode == pcm_pkg::OP_FINISH);
   assign count_eff     = phase_done_ff ? '0 : count_ff;
   assign file_wr_en    = accept && (req_bus.opcode == pcm_pkg::OP_LOAD) &&
                          (count_eff < pcm_pkg::CNT_W'(pcm_pkg::MAX_BYTES));
   assign fetch_ok      = phase_done_ff && (status_ff == pcm_pkg::ST_OK) &&
                          (pos_ff < fin.total);
   assign rsp_set       = (accept && (req_bus.opcode == pcm_pkg::OP_FETCH) && !fetch_ok) ||
                          ((state_ff == T_FINISH) && fin.done) || (state_ff == T_FETCH);

   pcm_byte_ram #(.DEPTH(pcm_pkg::MAX_BYTES), .AW(pcm_pkg::ADDR_W)) u_file_ram (
      .clock   (clock),
      .wr_en   (file_wr_en),
      .wr_addr (count_eff[pcm_pkg::ADDR_W-1:0]),
      .wr_data (req_bus.data_byte),
      .rd_addr (file_rd_addr),
      .rd_data (file_rd_data)
   );

   pcm_byte_ram #(.DEPTH(pcm_pkg::OUT_DEPTH), .AW(pcm_pkg::OUT_AW)) u_out_ram (
      .clock   (clock),
      .wr_en   (out_wr_en),
      .wr_addr (out_wr_addr),
      .wr_data (out_wr_data),
      .rd_addr (pcm_pkg::OUT_AW'(pos_ff)),
      .rd_data (out_rd_data)
   );

   pcm_walker u_walker (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .overflow     (overflow_ff),
      .byte_count   (count_ff),
      .file_rd_addr (file_rd_addr),
      .file_rd_data (file_rd_data),
      .out_wr_en    (out_wr_en),
      .out_wr_addr  (out_wr_addr),
      .out_wr_data  (out_wr_data),
      .fin          (fin)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= T_IDLE;
         count_ff      <= '0;
         overflow_ff   <= 1'b0;
         phase_done_ff <= 1'b0;
         status_ff     <= pcm_pkg::ST_OK;
         pos_ff        <= '0;
         last_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_bus.ready && !rsp_set) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            T_IDLE: begin
               if (accept) begin
                  unique case (req_bus.opcode)
                     pcm_pkg::OP_LOAD: begin
                        if (phase_done_ff) begin
                           phase_done_ff <= 1'b0;
                           status_ff     <= pcm_pkg::ST_OK;
                           pos_ff        <= '0;
                           overflow_ff   <= 1'b0;
                        end
                        if (file_wr_en) begin
                           count_ff <= count_eff + pcm_pkg::CNT_W'(1);
                        end else begin
                           count_ff    <= count_eff;
                           overflow_ff <= 1'b1;
                        end
                     end
                     pcm_pkg::OP_FINISH: begin
                        pos_ff        <= '0;
                        phase_done_ff <= 1'b1;
                        state_ff      <= T_FINISH;
                     end
                     pcm_pkg::OP_FETCH: begin
                        if (fetch_ok) begin
                           last_ff  <= (pos_ff + pcm_pkg::LEN_W'(1)) == fin.total;
                           pos_ff   <= pos_ff + pcm_pkg::LEN_W'(1);
                           state_ff <= T_FETCH;
                        end else begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_kind_ff   <= pcm_pkg::KIND_BYTE;
                           rsp_status_ff <= status_ff;
                           rsp_len_ff    <= (phase_done_ff && (status_ff == pcm_pkg::ST_OK))
                                            ? fin.total : '0;
                           rsp_byte_ff   <= '0;
                           rsp_last_ff   <= 1'b0;
                           rsp_past_ff   <= 1'b1;
                        end
                     end
                     default: begin
                     end
                  endcase
               end
            end
            T_FINISH: begin
               if (fin.done) begin
                  status_ff     <= fin.status;
                  rsp_valid_ff  <= 1'b1;
                  rsp_kind_ff   <= pcm_pkg::KIND_REPORT;
                  rsp_status_ff <= fin.status;
                  rsp_len_ff    <= (fin.status == pcm_pkg::ST_OK) ? fin.total : '0;
                  rsp_byte_ff   <= '0;
                  rsp_last_ff   <= 1'b0;
                  rsp_past_ff   <= 1'b0;
                  state_ff      <= T_IDLE;
               end
            end
            T_FETCH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_kind_ff   <= pcm_pkg::KIND_BYTE;
               rsp_status_ff <= status_ff;
               rsp_len_ff    <= fin.total;
               rsp_byte_ff   <= out_rd_data;
               rsp_last_ff   <= last_ff;
               rsp_past_ff   <= 1'b0;
               state_ff      <= T_IDLE;
            end
            default: begin
               state_ff <= T_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.kind       = rsp_kind_ff;
   assign rsp_bus.status     = rsp_status_ff;
   assign rsp_bus.out_length = rsp_len_ff;
   assign rsp_bus.out_byte   = rsp_byte_ff;
   assign rsp_bus.last_byte  = rsp_last_ff;
   assign rsp_bus.past_end   = rsp_past_ff;

endmodule

// File: src/pcm_checker.sv
// ----------------------------------------------------------------------------
// pcm_checker
// port level checks on the response channel of the chunk minifier
// ----------------------------------------------------------------------------
module pcm_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic                      rsp_kind,
   input logic [1:0]                rsp_status,
   input logic [pcm_pkg::LEN_W-1:0] rsp_out_length,
   input logic [7:0]                rsp_out_byte,
   input logic                      rsp_last_byte,
   input logic                      rsp_past_end
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_kind))
      else $error("response word changed while stalled");

   a_past_end_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_past_end |-> rsp_out_byte == 8'd0 && !rsp_last_byte)
      else $error("past end word carries data");

   a_report_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == pcm_pkg::KIND_REPORT |->
         !rsp_past_end && !rsp_last_byte && rsp_out_byte == 8'd0)
      else $error("report word has byte fields set");

   a_len_on_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != pcm_pkg::ST_OK |-> rsp_out_length == '0)
      else $error("length given with error status");

endmodule

bind png_chunk_minifier_unit pcm_checker u_pcm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_status     (rsp_bus.status),
   .rsp_out_length (rsp_bus.out_length),
   .rsp_out_byte   (rsp_bus.out_byte),
   .rsp_last_byte  (rsp_bus.last_byte),
   .rsp_past_end   (rsp_bus.past_end)
);
